/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the bound checker in hw/rtl/hfma_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hw/rtl/hfma_pkg.sv */
`timescale 1ns / 1ps
package hfma_pkg;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_ADD = 2'd2;
    localparam logic [1:0] OP_FMA = 2'd3;
    localparam logic [15:0] QNAN16 = 16'hFE00;
    localparam logic [15:0] INF16  = 16'h7C00;
    localparam logic [15:0] ONE16  = 16'h3C00;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addend;
        logic [15:0] multiplicand;
        logic [15:0] multiplier;
    } t_in_word;

    typedef struct packed {
        logic [15:0] result;
    } t_out_word;
endpackage

/* hw/rtl/hfma_if.sv */
`timescale 1ns / 1ps
interface hfma_in_if;
    logic               valid;
    logic               ready;
    hfma_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hfma_out_if;
    logic                valid;
    logic                ready;
    hfma_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/hfma_core.sv */
`timescale 1ns / 1ps
// Combinational datapath: sum in units of 2^-27 (product with a sticky bit), truncated to binary16.
module hfma_core (
    input  hfma_pkg::t_in_word i_word,
    output logic [15:0]        o_result
);
    import hfma_pkg::*;

    logic [15:0] a, b, c;
    logic        sa, sb, sc, sp, sign;
    logic [4:0]  xa, xb, xc, ea, eb, ec;
    logic [9:0]  fa, fb, fc;
    logic [10:0] ma, mb, mc;
    logic        nan_any, inf_a, inf_b, inf_c, zero_b, zero_c;
    logic [21:0] mp;
    logic [6:0]  shf;
    logic [4:0]  rs;
    logic [63:0] av, pv, mag, mpw, q;
    logic        lost;
    logic [5:0]  h;
    logic [5:0]  be;

    always_comb begin
        a = (i_word.op == OP_MUL) ? 16'h0000 : i_word.addend;
        b = i_word.multiplicand;
        c = (i_word.op == OP_ADD) ? ONE16 : i_word.multiplier;
        {sa, xa, fa} = a;
        {sb, xb, fb} = b;
        {sc, xc, fc} = c;
        ma = {(xa != 5'd0), fa};
        mb = {(xb != 5'd0), fb};
        mc = {(xc != 5'd0), fc};
        ea = (xa == 5'd0) ? 5'd1 : xa;
        eb = (xb == 5'd0) ? 5'd1 : xb;
        ec = (xc == 5'd0) ? 5'd1 : xc;
        inf_a  = (xa == 5'h1F) && (fa == 10'd0);
        inf_b  = (xb == 5'h1F) && (fb == 10'd0);
        inf_c  = (xc == 5'h1F) && (fc == 10'd0);
        zero_b = (xb == 5'd0) && (fb == 10'd0);
        zero_c = (xc == 5'd0) && (fc == 10'd0);
        nan_any = ((xa == 5'h1F) && (fa != 10'd0)) || ((xb == 5'h1F) && (fb != 10'd0))
               || ((xc == 5'h1F) && (fc != 10'd0)) || (inf_b && zero_c) || (inf_c && zero_b);
        sp = sb ^ sc;

        av  = {53'd0, ma} << ({1'b0, ea} + 6'd2);
        mp  = mb * mc;
        mpw = {42'd0, mp};
        shf = {2'b00, eb} + {2'b00, ec} - 7'd23;
        rs  = 5'(7'd0 - shf);
        q   = mpw >> rs;
        lost = ((mpw & ((64'd1 << rs) - 64'd1)) != 64'd0) || q[0];
        if (!shf[6]) pv = mpw << shf[5:0];
        else         pv = {q[63:1], lost};

        if (sa == sp) begin
            mag = av + pv; sign = sa;
        end else if (av >= pv) begin
            mag = av - pv; sign = sa;
        end else begin
            mag = pv - av; sign = sp;
        end

        h = 6'd0;
        for (int i = 1; i < 64; i++) if (mag[i]) h = 6'(i);
        be = h - 6'd12;

        if (nan_any || ((inf_b || inf_c) && inf_a && sp != sa)) o_result = QNAN16;
        else if (inf_b || inf_c) o_result = {sp, INF16[14:0]};
        else if (inf_a)          o_result = {sa, INF16[14:0]};
        else if (mag == 64'd0)   o_result = 16'h0000;
        else if (h >= 6'd13) begin
            if (be >= 6'd31) o_result = {sign, INF16[14:0]};
            else o_result = {sign, be[4:0], 10'(mag >> (h - 6'd10))};
        end else o_result = {sign, 5'd0, mag[12:3]};
    end
endmodule

/* hw/rtl/half_precision_fused_multiply_add_unit.sv */
`timescale 1ns / 1ps
// Half-precision fused multiply-add unit, truncating toward zero; overflow gives infinity.
// Input channel i_in carries one word: op, addend, multiplicand, multiplier.
// op 1 multiplies, op 2 adds addend and multiplicand, op 3 (and 0) computes
// addend + multiplicand * multiplier with a single truncation.
// Output channel o_out carries one word: the binary16 result; NaN is 0xFE00.
// Accepted input words go into an input register; the whole arithmetic is
// one combinational pass from that register into the result register.
// A result becomes valid when its word moves from the input register into the
// result register; a stall on the output can hold it in the input register.
// Throughput is one word per cycle while the receiver keeps taking results; the
// two register stages advance together whenever the result register is empty or is being taken.
// On a receiver stall the result register holds, an empty input register
// still fills, and ready drops once both are full; no word is lost or repeated.
// Reset (i_rst_n low, synchronous) empties both stages.
module half_precision_fused_multiply_add_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hfma_in_if.sink     i_in,
    hfma_out_if.source  o_out
);
    import hfma_pkg::*;

    logic     r_in_vld, r_out_vld, adv;
    t_in_word r_in;
    logic [15:0] r_res, n_res;

    // The pipe moves when the output stage frees up.
    assign adv        = !r_out_vld || o_out.ready;
    assign i_in.ready = adv || !r_in_vld;

    hfma_core u_core (.i_word(r_in), .o_result(n_res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv) r_out_vld <= r_in_vld;
            if (i_in.ready) r_in_vld <= i_in.valid;
        end
        if (adv && r_in_vld) r_res <= n_res;
        if (i_in.ready && i_in.valid) r_in <= i_in.data;
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.data.result = r_res;
endmodule

/* hw/rtl/hfma_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hfma_assertions (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_result
);
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_result), "stalled result changed")
    `ASSERT_CLK(a_ready_free, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "ready low with empty output")
    `ASSERT_CLK(a_latency, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_out_valid |=> ##1 i_out_valid, "result missing after two cycles")
    `ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !i_out_valid, "valid after reset")
endmodule

bind half_precision_fused_multiply_add_unit hfma_assertions u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_result(o_out.data.result)
);

/* tb/hfma_checker.sv */
`timescale 1ns / 1ps
module hfma_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hfma_in_if.sink     i_in_mon,
    hfma_out_if.sink    i_out_mon,
    output int          o_fail_count,
    output int          o_pending
);
    import hfma_pkg::*;

    logic [15:0] fma_expected_q[$];

    // Splits a binary16 pattern into significand and effective exponent.
    function automatic void unpack_half(input logic [15:0] x, output logic [10:0] mant,
                                        output int unsigned eff);
        if (x[14:10] == 5'd0) begin
            mant = {1'b0, x[9:0]};
            eff  = 1;
        end else begin
            mant = {1'b1, x[9:0]};
            eff  = x[14:10];
        end
    endfunction

    function automatic logic [15:0] fma_truncate(input logic [1:0] op, input logic [15:0] a_in,
                                                 input logic [15:0] b,
                                                 input logic [15:0] c_in);
        logic [15:0] a, c;
        logic [10:0] ma, mb, mc;
        int unsigned ea, eb, ec, hb, be;
        logic nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zero_b, zero_c, sp, sgn, lost;
        logic [63:0] av, pv, mp, mag, q;
        int sh;
        a = (op == OP_MUL) ? 16'h0000 : a_in;
        c = (op == OP_ADD) ? ONE16 : c_in;
        unpack_half(a, ma, ea);
        unpack_half(b, mb, eb);
        unpack_half(c, mc, ec);
        nan_a  = (a[14:10] == 5'h1f) && (a[9:0] != 0);
        nan_b  = (b[14:10] == 5'h1f) && (b[9:0] != 0);
        nan_c  = (c[14:10] == 5'h1f) && (c[9:0] != 0);
        inf_a  = (a[14:10] == 5'h1f) && (a[9:0] == 0);
        inf_b  = (b[14:10] == 5'h1f) && (b[9:0] == 0);
        inf_c  = (c[14:10] == 5'h1f) && (c[9:0] == 0);
        zero_b = (b[14:0] == 0);
        zero_c = (c[14:0] == 0);
        sp = b[15] ^ c[15];
        if (nan_a || nan_b || nan_c || (inf_b && zero_c) || (inf_c && zero_b))
            return QNAN16;
        if ((inf_b || inf_c) && inf_a && sp != a[15]) return QNAN16;
        if (inf_b || inf_c) return {sp, 15'h0} | INF16;
        if (inf_a) return {a[15], 15'h0} | INF16;
        // Fixed point with one unit equal to 2^-27; the product keeps a sticky bit.
        av = 64'(ma) << (ea + 2);
        mp = 64'(mb) * 64'(mc);
        sh = int'(eb) + int'(ec) - 23;
        if (sh >= 0) begin
            pv = mp << sh;
        end else begin
            q = mp >> (-sh);
            lost = ((mp & ((64'd1 << (-sh)) - 1)) != 0) || q[0];
            pv = {q[63:1], lost};
        end
        if (a[15] == sp) begin
            mag = av + pv;
            sgn = a[15];
        end else if (av >= pv) begin
            mag = av - pv;
            sgn = a[15];
        end else begin
            mag = pv - av;
            sgn = sp;
        end
        if (mag == 0) return 16'h0000;
        hb = 0;
        for (int i = 0; i < 64; i++) if (mag[i]) hb = i;
        if (hb >= 13) begin
            be = hb - 12;
            if (be >= 31) return {sgn, 15'h0} | INF16;
            return {sgn, 5'(be), 10'(mag >> (hb - 10))};
        end
        return {sgn, 5'd0, 10'(mag >> 3)};
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready)
                fma_expected_q.push_back(fma_truncate(i_in_mon.data.op,
                    i_in_mon.data.addend, i_in_mon.data.multiplicand,
                    i_in_mon.data.multiplier));
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (fma_expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h", i_out_mon.data.result));
                end else begin
                    if (i_out_mon.data.result !== fma_expected_q[0])
                        report_mismatch($sformatf("result %h, expected %h",
                                        i_out_mon.data.result, fma_expected_q[0]));
                    void'(fma_expected_q.pop_front());
                end
            end
        end
        o_pending = fma_expected_q.size();
    end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import hfma_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    logic stall_mode = 1'b0;

    hfma_in_if  in_ch();
    hfma_out_if out_ch();

    half_precision_fused_multiply_add_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    hfma_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_mon(in_ch.sink), .i_out_mon(out_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Picks an operand pattern, favoring specials and values near each other.
    function automatic logic [15:0] pick_half();
        logic [15:0] specials[10] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                                      16'h7C01, 16'h0001, 16'h03FF, 16'h7BFF, 16'h3C00};
        case ($urandom_range(0, 9))
            0: return specials[$urandom_range(0, 9)];
            1: return {1'($urandom), 5'($urandom_range(0, 1)), 10'($urandom)};
            2, 3, 4: return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    // Drives one word and holds it until the unit takes it.
    task automatic send_word(input logic [1:0] op, input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c);
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{op: op, addend: a, multiplicand: b, multiplier: c};
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // The receiver alternates between long ready stretches and random stalling.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        out_ch.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    // A run ends when nothing has been accepted for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [1:0] op;
        int burst;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        idle_cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: each operation, extremes, every special case.
        send_word(OP_FMA, 16'h3C00, 16'h4000, 16'h4200);
        send_word(OP_MUL, 16'h7E00, 16'h3C00, 16'hC000);   // NaN addend ignored
        send_word(OP_ADD, 16'h3C00, 16'h4000, 16'h7E00);   // NaN multiplier ignored
        send_word(2'd0,   16'h3C00, 16'h4000, 16'h4200);   // code zero acts as fused
        send_word(OP_FMA, 16'h0000, 16'h7E00, 16'h3C00);
        send_word(OP_FMA, 16'h7C01, 16'h3C00, 16'h3C00);
        send_word(OP_MUL, 16'h0000, 16'h7C00, 16'h0000);   // inf times zero
        send_word(OP_MUL, 16'h0000, 16'h8000, 16'hFC00);
        send_word(OP_FMA, 16'h7C00, 16'hFC00, 16'h3C00);   // inf minus inf
        send_word(OP_FMA, 16'hFC00, 16'hFC00, 16'h3C00);
        send_word(OP_FMA, 16'hFC00, 16'h3C00, 16'h3C00);
        send_word(OP_MUL, 16'h0000, 16'h7BFF, 16'h7BFF);   // overflow
        send_word(OP_MUL, 16'h0000, 16'hFBFF, 16'h7BFF);
        send_word(OP_ADD, 16'h7BFF, 16'h7BFF, 16'h0000);
        send_word(OP_ADD, 16'h3C00, 16'hBC00, 16'h0000);   // exact zero
        send_word(OP_FMA, 16'h8000, 16'h8000, 16'h3C00);
        send_word(OP_MUL, 16'h0000, 16'h0001, 16'h0001);   // underflow to zero
        send_word(OP_MUL, 16'h0000, 16'h8001, 16'h0001);
        send_word(OP_ADD, 16'h0001, 16'h03FF, 16'h0000);
        send_word(OP_FMA, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(OP_FMA, 16'h0400, 16'h8001, 16'h3800);

        // Wait for the pipeline to drain once with the sender held off.
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        for (int n = 0; n < 1350; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++) begin
                op = 2'($urandom);
                send_word(op, pick_half(), pick_half(), pick_half());
                n++;
            end
            if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 6));
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hfma_pkg.sv
hw/rtl/hfma_if.sv
hw/rtl/hfma_core.sv
hw/rtl/half_precision_fused_multiply_add_unit.sv
hw/rtl/hfma_checker.sv
tb/hfma_checker.sv
tb/testbench.sv
